// File: rtl/edr_pkg.sv
// Shared types and constants for the EMA deadband reporter.
// Depends on nothing; imported by the channel interfaces, the lane and the top level.
`timescale 1ns / 1ps

package edr_pkg;

	localparam int ALPHA_W     = 9;
	localparam int ALPHA_SHIFT = 8;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	localparam int TEMP_W  = 11;
	localparam int HUMID_W = 10;

	localparam int GAS_RANGE_W   = 12;
	localparam int FLAME_RANGE_W = 12;
	localparam int TEMP_RANGE_W  = 11;
	localparam int HUMID_RANGE_W = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam int LANES = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAS_ALPHA   = 3'd0,
		REG_FLAME_ALPHA = 3'd1,
		REG_TEMP_ALPHA  = 3'd2,
		REG_HUMID_ALPHA = 3'd3,
		REG_GAS_RANGE   = 3'd4,
		REG_FLAME_RANGE = 3'd5,
		REG_TEMP_RANGE  = 3'd6,
		REG_HUMID_RANGE = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic upd;
		logic commit;
	} lane_ctl_t;

	typedef struct packed {
		logic seeded;
		logic sent;
		logic want;
	} lane_stat_t;

	function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
		return (a > ALPHA_ONE) ? ALPHA_ONE : a;
	endfunction

endpackage

// File: rtl/edr_sample_if.sv
// Sample channel: valid/ready handshake carrying one sensor sample set per word.
// Depends on edr_pkg for the climate field widths.
`timescale 1ns / 1ps

interface edr_sample_if import edr_pkg::*; #(
	parameter int ADC_BITS = 12
);
	logic                       valid;
	logic                       ready;
	logic        [ADC_BITS-1:0] gas_raw;
	logic        [ADC_BITS-1:0] flame_raw;
	logic signed [TEMP_W-1:0]   temp_tenths;
	logic        [HUMID_W-1:0]  humid_tenths;
	logic                       climate_ok;
	logic        [31:0]         now_ms;
	logic                       tx_ready;

	modport source (output valid, gas_raw, flame_raw, temp_tenths, humid_tenths,
		climate_ok, now_ms, tx_ready, input ready);
	modport sink (input valid, gas_raw, flame_raw, temp_tenths, humid_tenths,
		climate_ok, now_ms, tx_ready, output ready);
endinterface

// File: rtl/edr_report_if.sv
// Report channel: valid/ready handshake carrying the four averages per word.
// Depends on edr_pkg for the climate field widths.
`timescale 1ns / 1ps

interface edr_report_if import edr_pkg::*; #(
	parameter int ADC_BITS  = 12,
	parameter int FRAC_BITS = 8
);
	logic                                valid;
	logic                                ready;
	logic        [ADC_BITS+FRAC_BITS-1:0] gas_ema;
	logic        [ADC_BITS+FRAC_BITS-1:0] flame_ema;
	logic signed [TEMP_W+FRAC_BITS-1:0]   temp_ema;
	logic        [HUMID_W+FRAC_BITS-1:0]  humid_ema;
	logic                                temp_valid;
	logic                                humid_valid;

	modport source (output valid, gas_ema, flame_ema, temp_ema, humid_ema,
		temp_valid, humid_valid, input ready);
	modport sink (input valid, gas_ema, flame_ema, temp_ema, humid_ema,
		temp_valid, humid_valid, output ready);
endinterface

// File: rtl/edr_lane.sv
// One averaging lane: fixed-point EMA update, last-sent value and deadband test.
// Depends on edr_pkg for the control and status structs.
`timescale 1ns / 1ps

module edr_lane import edr_pkg::*; #(
	parameter int XW        = 12,
	parameter bit XS        = 1'b0,
	parameter int RW        = 12,
	parameter int FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic [XW-1:0]           x,
	input  logic [ALPHA_W-1:0]      alpha,
	input  logic [RW-1:0]           range_lim,
	output logic [XW+FRAC_BITS-1:0] avg,
	output lane_stat_t              stat
);
	localparam int AW = XW + FRAC_BITS;
	localparam int PW = AW + ALPHA_W + 3;

	logic [AW-1:0] avg_q;
	logic [AW-1:0] last_q;
	logic          seeded_q;
	logic          sent_q;

	logic signed [PW-1:0] x_p, target_p, avg_p, last_p, a_p, diff_p, prod_p, step_p, sum_p;
	logic signed [PW-1:0] d_p, mag_p, thresh_p;

	always_comb begin
		x_p      = XS ? $signed({{(PW-XW){x[XW-1]}}, x}) : $signed({{(PW-XW){1'b0}}, x});
		avg_p    = XS ? $signed({{(PW-AW){avg_q[AW-1]}}, avg_q})
			: $signed({{(PW-AW){1'b0}}, avg_q});
		last_p   = XS ? $signed({{(PW-AW){last_q[AW-1]}}, last_q})
			: $signed({{(PW-AW){1'b0}}, last_q});
		target_p = x_p <<< FRAC_BITS;
		a_p      = $signed({{(PW-ALPHA_W){1'b0}}, clamp_alpha(alpha)});
		diff_p   = target_p - avg_p;
		prod_p   = a_p * diff_p;
		step_p   = prod_p >>> ALPHA_SHIFT;
		sum_p    = avg_p + step_p;
		d_p      = avg_p - last_p;
		mag_p    = d_p[PW-1] ? -d_p : d_p;
		thresh_p = $signed({{(PW-RW-FRAC_BITS){1'b0}}, range_lim, {FRAC_BITS{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q    <= '0;
			seeded_q <= 1'b0;
		end else if (ctl.upd) begin
			avg_q    <= seeded_q ? sum_p[AW-1:0] : target_p[AW-1:0];
			seeded_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			sent_q <= 1'b0;
		end else if (ctl.commit && seeded_q) begin
			last_q <= avg_q;
			sent_q <= 1'b1;
		end
	end

	assign avg         = avg_q;
	assign stat.seeded = seeded_q;
	assign stat.sent   = sent_q;
	assign stat.want   = seeded_q && (!sent_q || ($unsigned(mag_p) > $unsigned(thresh_p)));

endmodule

// File: rtl/ema_deadband_reporter.sv
// Top level: configuration registers, four averaging lanes, report merge and output register.
// Depends on edr_pkg, edr_sample_if, edr_report_if and edr_lane.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake    | word
//  sample   | in        | valid/ready  | gas, flame, temp, humid, climate_ok, now_ms, tx_ready
//  report   | out       | valid/ready  | four averages, temp_valid, humid_valid
//  cfg      | in        | cfg_we       | cfg_index, cfg_data, no read-back
//
//  One sample word per cycle unless a held report stalls the second stage; a report that
//  the second stage sends is loaded into the output register. First stage: lane multiply-add
//  updates the averages. Second stage: deadband tests, gap check, merge and last-sent update,
//  result into the output register. Reset clears all averages, last-sent values, seeded and
//  sent flags and the send time. A held report stalls the second stage only when that stage also has a report to give.

module ema_deadband_reporter import edr_pkg::*; #(
	parameter logic [31:0] MIN_GAP_MS = 32'd5000,
	parameter int          FRAC_BITS  = 8,
	parameter int          ADC_BITS   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	edr_sample_if.sink            sample,
	edr_report_if.source          report,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int GW = ADC_BITS + FRAC_BITS;
	localparam int TW = TEMP_W + FRAC_BITS;
	localparam int HW = HUMID_W + FRAC_BITS;

	logic [ALPHA_W-1:0]       gas_alpha_q, flame_alpha_q, temp_alpha_q, humid_alpha_q;
	logic [GAS_RANGE_W-1:0]   gas_range_q;
	logic [FLAME_RANGE_W-1:0] flame_range_q;
	logic [TEMP_RANGE_W-1:0]  temp_range_q;
	logic [HUMID_RANGE_W-1:0] humid_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_alpha_q   <= 9'd77;
			flame_alpha_q <= 9'd64;
			temp_alpha_q  <= 9'd38;
			humid_alpha_q <= 9'd51;
			gas_range_q   <= 12'd15;
			flame_range_q <= 12'd15;
			temp_range_q  <= 11'd5;
			humid_range_q <= 10'd20;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAS_ALPHA:   gas_alpha_q   <= cfg_data[ALPHA_W-1:0];
				REG_FLAME_ALPHA: flame_alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_TEMP_ALPHA:  temp_alpha_q  <= cfg_data[ALPHA_W-1:0];
				REG_HUMID_ALPHA: humid_alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_GAS_RANGE:   gas_range_q   <= cfg_data[GAS_RANGE_W-1:0];
				REG_FLAME_RANGE: flame_range_q <= cfg_data[FLAME_RANGE_W-1:0];
				REG_TEMP_RANGE:  temp_range_q  <= cfg_data[TEMP_RANGE_W-1:0];
				REG_HUMID_RANGE: humid_range_q <= cfg_data[HUMID_RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	logic        valid_s1;
	logic [31:0] now_s1;
	logic        tx_ready_s1;
	logic [31:0] last_send_q;
	logic        out_valid_q;

	logic        in_accept, s1_move, send, commit, gap_ok;
	lane_ctl_t   ctl_clk, ctl_fast;
	lane_stat_t  stat [LANES];
	logic [LANES-1:0] want, seeded, sent;

	logic [GW-1:0] gas_avg, flame_avg;
	logic [TW-1:0] temp_avg;
	logic [HW-1:0] humid_avg;

	assign in_accept = sample.valid && sample.ready;
	assign gap_ok    = (now_s1 - last_send_q) >= MIN_GAP_MS;
	assign send      = valid_s1 && gap_ok && (|want);
	assign s1_move   = valid_s1 && (!send || !out_valid_q || report.ready);
	assign commit    = s1_move && send && tx_ready_s1;
	assign sample.ready = !valid_s1 || s1_move;

	assign ctl_fast.upd    = in_accept;
	assign ctl_fast.commit = commit;
	assign ctl_clk.upd     = in_accept && sample.climate_ok;
	assign ctl_clk.commit  = commit;

	edr_lane #(.XW(ADC_BITS), .XS(1'b0), .RW(GAS_RANGE_W), .FRAC_BITS(FRAC_BITS)) u_gas (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_fast), .x(sample.gas_raw),
		.alpha(gas_alpha_q), .range_lim(gas_range_q), .avg(gas_avg), .stat(stat[0])
	);
	edr_lane #(.XW(ADC_BITS), .XS(1'b0), .RW(FLAME_RANGE_W), .FRAC_BITS(FRAC_BITS)) u_flame (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_fast), .x(sample.flame_raw),
		.alpha(flame_alpha_q), .range_lim(flame_range_q), .avg(flame_avg), .stat(stat[1])
	);
	edr_lane #(.XW(TEMP_W), .XS(1'b1), .RW(TEMP_RANGE_W), .FRAC_BITS(FRAC_BITS)) u_temp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_clk), .x(sample.temp_tenths),
		.alpha(temp_alpha_q), .range_lim(temp_range_q), .avg(temp_avg), .stat(stat[2])
	);
	edr_lane #(.XW(HUMID_W), .XS(1'b0), .RW(HUMID_RANGE_W), .FRAC_BITS(FRAC_BITS)) u_humid (
		.clk(clk), .arst_n(arst_n), .ctl(ctl_clk), .x(sample.humid_tenths),
		.alpha(humid_alpha_q), .range_lim(humid_range_q), .avg(humid_avg), .stat(stat[3])
	);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			want[i]   = stat[i].want;
			seeded[i] = stat[i].seeded;
			sent[i]   = stat[i].sent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_send_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				valid_s1 <= 1'b1;
			else if (s1_move)
				valid_s1 <= 1'b0;
			if (commit)
				last_send_q <= now_s1;
			if (s1_move && send)
				out_valid_q <= 1'b1;
			else if (report.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_s1      <= sample.now_ms;
			tx_ready_s1 <= sample.tx_ready;
		end
	end

	logic [GW-1:0]        gas_out_q, flame_out_q;
	logic signed [TW-1:0] temp_out_q;
	logic [HW-1:0]        humid_out_q;
	logic                 temp_vld_q, humid_vld_q;

	always_ff @(posedge clk) begin
		if (s1_move && send) begin
			gas_out_q   <= gas_avg;
			flame_out_q <= flame_avg;
			temp_out_q  <= seeded[2] ? $signed(temp_avg) : '0;
			humid_out_q <= seeded[3] ? humid_avg : '0;
			temp_vld_q  <= seeded[2];
			humid_vld_q <= seeded[3];
		end
	end

	assign report.valid       = out_valid_q;
	assign report.gas_ema     = gas_out_q;
	assign report.flame_ema   = flame_out_q;
	assign report.temp_ema    = temp_out_q;
	assign report.humid_ema   = humid_out_q;
	assign report.temp_valid  = temp_vld_q;
	assign report.humid_valid = humid_vld_q;

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && send |=> out_valid_q)
		else $error("report not registered after send");
	a_send_time: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> last_send_q == $past(now_s1))
		else $error("send time not updated on commit");
	a_sent_cover: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (sent & $past(seeded)) == $past(seeded))
		else $error("seeded channel not marked sent");
	a_hold_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !report.ready |=> out_valid_q && $stable(gas_out_q))
		else $error("held report dropped or changed");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !report.ready && send |-> !s1_move)
		else $error("report overwrites a held report");

endmodule
